// ===== rtl/core/encoder_speed_averager_assert.svh =====
// Assertion macros for the encoder speed averager.
// Used by encoder_speed_averager.sv; expects signals named clock and reset in scope.
`ifndef ENCODER_SPEED_AVERAGER_ASSERT_SVH
`define ENCODER_SPEED_AVERAGER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ESA_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ESA_ASSERT_IMPLIES(label, ante, cons, msg)
`define ESA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/esa_pkg.sv =====
// Shared types and constants for the encoder speed averager.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package esa_pkg;

   localparam int LINES_W     = 13;
   localparam int LIMIT_W     = 11;
   localparam int COUNT_W     = 15;
   localparam int WRAPS_W     = 16;
   localparam int SPEED_W     = 16;
   localparam int AVG_W       = 11;
   localparam int PREV_W      = 16;
   localparam int SUM_W       = 16;
   localparam int DELTA_W     = 32;
   localparam int SPAN_W      = 31;
   localparam int EDGE_SHIFT  = 2;      // four counter edges per line
   localparam int PERIOD_W    = LINES_W + EDGE_SHIFT;
   localparam int SCALE_W     = 13;
   localparam int QUO_W       = 44;     // |delta| * 6000 < 2**44
   localparam int RADIX_BITS  = 2;      // quotient bits per divide cycle
   localparam int DIV_STEPS   = QUO_W / RADIX_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int DATA_W      = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_BIT = 2;

   localparam logic [LINES_W-1:0] LINES_RESET = 13'd1024;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1600;
   localparam logic [SCALE_W-1:0] SPEED_SCALE = 13'd6000;

   // register index codes (paddr bit CSR_IDX_BIT)
   localparam logic REG_LINES_PER_REV = 1'b0;
   localparam logic REG_SPEED_LIMIT   = 1'b1;

   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic               func;
      logic [COUNT_W-1:0] count_value;
      logic [WRAPS_W-1:0] overflow_count;
      logic               count_down;
   } req_type;

   typedef struct packed {
      logic [AVG_W-1:0]          average_speed;
      logic signed [SPEED_W-1:0] raw_speed;
      logic                      stored;
   } rsp_type;

   typedef struct packed {
      logic [LINES_W-1:0] lines_per_rev;
      logic [LIMIT_W-1:0] speed_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic zero_speed;
      logic span;
      logic diff;
      logic scale;
      logic div_step;
      logic sign;
      logic store;
      logic mean;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic first_sample;
   } status_type;

endpackage

// ===== rtl/core/esa_csr.sv =====
// Configuration registers (lines per revolution, speed limit) behind an APB-style port.
// Depends on esa_pkg.
`timescale 1ns / 1ps

module esa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [esa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [esa_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [esa_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready,
   output esa_pkg::cfg_type                  cfg
);

   logic [esa_pkg::LINES_W-1:0] lines_ff, lines_in;
   logic [esa_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                        wr_en;
   logic                        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[esa_pkg::CSR_IDX_BIT];

   always_comb begin
      lines_in = lines_ff;
      limit_in = limit_ff;
      if (wr_en) begin
         unique case (reg_idx)
            esa_pkg::REG_LINES_PER_REV: lines_in = csr_pwdata[esa_pkg::LINES_W-1:0];
            esa_pkg::REG_SPEED_LIMIT:   limit_in = csr_pwdata[esa_pkg::LIMIT_W-1:0];
            default:                    lines_in = lines_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         esa_pkg::REG_LINES_PER_REV: csr_prdata = esa_pkg::DATA_W'(lines_ff);
         esa_pkg::REG_SPEED_LIMIT:   csr_prdata = esa_pkg::DATA_W'(limit_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff <= esa_pkg::LINES_RESET;
         limit_ff <= esa_pkg::LIMIT_RESET;
      end else begin
         lines_ff <= lines_in;
         limit_ff <= limit_in;
      end
   end

   assign cfg.lines_per_rev = lines_ff;
   assign cfg.speed_limit   = limit_ff;

endmodule

// ===== rtl/core/esa_ctrl.sv =====
// Sequencer for the speed averager: steps the datapath through one transaction.
// Depends on esa_pkg; drives esa_datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps

module esa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  esa_pkg::status_type  status,
   output esa_pkg::cmd_type     cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DISPATCH = 9'b000000010,
      S_DIFF     = 9'b000000100,
      S_SCALE    = 9'b000001000,
      S_DIVIDE   = 9'b000010000,
      S_SIGN     = 9'b000100000,
      S_STORE    = 9'b001000000,
      S_MEAN     = 9'b010000000,
      S_FINISH   = 9'b100000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [esa_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;

   // output register can take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.is_clear) begin
               cmd.clear = 1'b1;
               state_in  = S_MEAN;
            end else if (status.first_sample) begin
               cmd.zero_speed = 1'b1;
               state_in       = S_STORE;
            end else begin
               cmd.span = 1'b1;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            cnt_in    = '0;
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == esa_pkg::DIV_CNT_W'(esa_pkg::DIV_STEPS - 1)) begin
               state_in = S_SIGN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SIGN: begin
            cmd.sign = 1'b1;
            state_in = S_STORE;
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = S_MEAN;
         end
         S_MEAN: begin
            cmd.mean = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/esa_datapath.sv =====
// Datapath: count delta, scaling, radix-4 restoring divider, history ring and mean.
// Depends on esa_pkg; sequenced by esa_ctrl.
`timescale 1ns / 1ps

module esa_datapath #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  esa_pkg::cmd_type     cmd,
   input  esa_pkg::cfg_type     cfg,
   input  esa_pkg::req_type     req_payload,
   output esa_pkg::status_type  status,
   output esa_pkg::rsp_type     rsp_payload
);

   localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   // mean = floor(sum / depth) via multiply by rounded-up reciprocal
   localparam int MEAN_SHIFT = esa_pkg::SUM_W + $clog2(HISTORY_DEPTH);
   localparam longint RECIP  = ((longint'(1) << MEAN_SHIFT) + longint'(HISTORY_DEPTH) - 1)
                               / longint'(HISTORY_DEPTH);
   localparam int RECIP_W    = esa_pkg::SUM_W + 2;
   localparam int PROD_W     = esa_pkg::SUM_W + RECIP_W;

   localparam int LW  = esa_pkg::LINES_W;
   localparam int PW  = esa_pkg::PERIOD_W;
   localparam int DW  = esa_pkg::DELTA_W;
   localparam int QW  = esa_pkg::QUO_W;
   localparam int SW  = esa_pkg::SPEED_W;
   localparam int EW  = esa_pkg::LIMIT_W;

   // transaction and working registers
   esa_pkg::req_type  req_ff, req_in;
   logic [PW-1:0]     period_ff, period_in;
   logic [DW-1:0]     span_ff, span_in;
   logic [DW-1:0]     diff0_ff, diff0_in;
   logic [DW-1:0]     mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [PW-1:0]     rem_ff, rem_in;
   logic [SW-1:0]     speed_ff, speed_in;
   logic              stored_ff, stored_in;
   logic [PROD_W-1:0] mean_ff, mean_in;
   esa_pkg::rsp_type  rsp_ff, rsp_in;

   // history state
   logic [esa_pkg::PREV_W-1:0] prev_ff, prev_in;
   logic                       first_ff, first_in;
   logic [EW-1:0]              hist_ff [HISTORY_DEPTH];
   logic [EW-1:0]              hist_in [HISTORY_DEPTH];
   logic [esa_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;

   // combinational values
   logic [LW-1:0]             lines_c;
   logic [PW-1:0]             period_c;
   logic [esa_pkg::SPAN_W-1:0] span_c;
   logic [DW-1:0]             delta_c;
   logic [QW-1:0]             scaled_c;
   logic [PW:0]               shifted_v;
   logic                      qbit_v;
   logic [PW-1:0]             rem_step;
   logic [QW-1:0]             quo_step;
   logic                      keep_c;
   logic [esa_pkg::SUM_W-1:0] sum_c;
   logic [SLOT_W-1:0]         slot_c;
   logic [RECIP_W-1:0]        recip_c;
   logic [PROD_W-1:0]         mean_c;

   // a zero line count behaves as one
   assign lines_c  = (cfg.lines_per_rev == '0) ? LW'(1) : cfg.lines_per_rev;
   assign period_c = PW'(lines_c) << esa_pkg::EDGE_SHIFT;
   assign span_c   = esa_pkg::SPAN_W'(req_ff.overflow_count) * esa_pkg::SPAN_W'(period_c);
   assign delta_c  = req_ff.count_down ? (diff0_ff - span_ff) : (diff0_ff + span_ff);
   assign scaled_c = QW'(mag_ff) * QW'(esa_pkg::SPEED_SCALE);

   // restoring divide, RADIX_BITS quotient bits per cycle
   always_comb begin
      rem_step  = rem_ff;
      quo_step  = quo_ff;
      shifted_v = '0;
      qbit_v    = 1'b0;
      for (int i = 0; i < esa_pkg::RADIX_BITS; i++) begin
         shifted_v = {rem_step, quo_step[QW-1]};
         qbit_v    = (shifted_v >= {1'b0, period_ff});
         rem_step  = qbit_v ? PW'(shifted_v - {1'b0, period_ff}) : shifted_v[PW-1:0];
         quo_step  = {quo_step[QW-2:0], qbit_v};
      end
   end

   // speeds at or above the limit, and all negative ones, stay out of the ring
   assign keep_c  = (speed_ff < SW'(cfg.speed_limit));
   assign sum_c   = sum_ff - esa_pkg::SUM_W'(hist_ff[slot_ff])
                           + esa_pkg::SUM_W'(speed_ff[EW-1:0]);
   assign slot_c  = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign recip_c = RECIP_W'(RECIP);
   assign mean_c  = PROD_W'(sum_ff) * PROD_W'(recip_c);

   always_comb begin
      req_in    = req_ff;
      period_in = period_ff;
      span_in   = span_ff;
      diff0_in  = diff0_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      speed_in  = speed_ff;
      stored_in = stored_ff;
      mean_in   = mean_ff;
      rsp_in    = rsp_ff;
      prev_in   = prev_ff;
      first_in  = first_ff;
      hist_in   = hist_ff;
      sum_in    = sum_ff;
      slot_in   = slot_ff;

      if (cmd.load) begin
         req_in = req_payload;
      end
      if (cmd.clear) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_in[i] = '0;
         end
         sum_in    = '0;
         first_in  = 1'b1;
         speed_in  = '0;
         stored_in = 1'b0;
      end
      if (cmd.zero_speed) begin
         speed_in = '0;
         first_in = 1'b0;
      end
      if (cmd.span) begin
         period_in = period_c;
         span_in   = DW'(span_c);
         diff0_in  = DW'(req_ff.count_value) - DW'(prev_ff);
      end
      if (cmd.diff) begin
         neg_in = delta_c[DW-1];
         mag_in = delta_c[DW-1] ? (~delta_c + 1'b1) : delta_c;
      end
      if (cmd.scale) begin
         quo_in = scaled_c;
         rem_in = '0;
      end
      if (cmd.div_step) begin
         quo_in = quo_step;
         rem_in = rem_step;
      end
      if (cmd.sign) begin
         // only the low bits survive, so negate them alone
         speed_in = neg_ff ? (~quo_ff[SW-1:0] + 1'b1) : quo_ff[SW-1:0];
      end
      if (cmd.store) begin
         prev_in   = esa_pkg::PREV_W'(req_ff.count_value);
         stored_in = keep_c;
         if (keep_c) begin
            hist_in[slot_ff] = speed_ff[EW-1:0];
            sum_in           = sum_c;
            slot_in          = slot_c;
         end
      end
      if (cmd.mean) begin
         mean_in = mean_c;
      end
      if (cmd.emit) begin
         rsp_in.average_speed = esa_pkg::AVG_W'(mean_ff >> MEAN_SHIFT);
         rsp_in.raw_speed     = speed_ff;
         rsp_in.stored        = stored_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         first_ff <= 1'b1;
         sum_ff   <= '0;
         slot_ff  <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         prev_ff  <= prev_in;
         first_ff <= first_in;
         sum_ff   <= sum_in;
         slot_ff  <= slot_in;
         hist_ff  <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      period_ff <= period_in;
      span_ff   <= span_in;
      diff0_ff  <= diff0_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      speed_ff  <= speed_in;
      stored_ff <= stored_in;
      mean_ff   <= mean_in;
      rsp_ff    <= rsp_in;
   end

   assign status.is_clear     = (req_ff.func == esa_pkg::FUNC_CLEAR);
   assign status.first_sample = first_ff;
   assign rsp_payload         = rsp_ff;

endmodule

// ===== rtl/core/encoder_speed_averager.sv =====
// Channel   Ports               Direction  Handshake
// request   req_*               in         valid / stall, one sample or clear per transaction
// response  rsp_*               out        valid / stall, one result per request
// config    csr_*               in/out     APB-style write and read, pready tied high
//
// A speed sample steps through dispatch, diff, scale, divide, sign, store, mean and finish before
// the next acceptance; the radix-4 divide of the scaled delta by the counter period is its longest part.
// A first sample after clear goes from dispatch to store, mean and finish; a clear goes to mean and finish.
// The result is registered and shows in the cycle after the last working cycle; the next
// request is taken while it waits. A stalled result holds the sequencer in its last state.
// Reset is synchronous and clears history, sum, write slot, previous count and sets the
// first-sample mark.
//
// Top level of the encoder speed averager; depends on esa_pkg, esa_csr, esa_ctrl,
// esa_datapath and encoder_speed_averager_assert.svh.
`timescale 1ns / 1ps
`include "encoder_speed_averager_assert.svh"

module encoder_speed_averager #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  esa_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output esa_pkg::rsp_type               rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [esa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [esa_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [esa_pkg::DATA_W-1:0]     csr_prdata,
   output logic                           csr_pready
);

   esa_pkg::cfg_type    cfg;
   esa_pkg::cmd_type    cmd;
   esa_pkg::status_type status;

   esa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   esa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   esa_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // one transaction at a time
   `ESA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted while busy")
   // never overwrite a result that is still stalled
   `ESA_ASSERT_IMPLIES(a_emit_free, cmd.emit, !rsp_valid || !rsp_stall, "result overwritten")
   // a stored speed is nonnegative and fits an 11-bit entry
   `ESA_ASSERT_IMPLIES(a_stored_range, rsp_valid && rsp_payload.stored,
      !rsp_payload.raw_speed[15] && (rsp_payload.raw_speed[14:11] == 4'd0), "bad stored speed")
   // clear re-arms the first-sample mark
   `ESA_ASSERT_NEXT(a_clear_first, cmd.clear, status.first_sample, "first mark not set")

endmodule

// ===== bench/tb_encoder_speed_averager.sv =====
`timescale 1ns / 1ps
// Self-checking bench for encoder_speed_averager: directed and random sample/clear traffic,
// checked per field against an in-bench speed and moving-average predictor.
// Depends on esa_pkg and the encoder_speed_averager RTL.

module tb_encoder_speed_averager;

   localparam int     HISTORY_DEPTH  = 8;
   localparam longint SPEED_FACTOR   = 6000;
   localparam int     EDGES_PER_LINE = 4;
   localparam logic   FUNC_SAMPLE    = ~esa_pkg::FUNC_CLEAR;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   esa_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   esa_pkg::rsp_type               rsp_payload;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [esa_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [esa_pkg::DATA_W-1:0]     csr_pwdata  = '0;
   logic [esa_pkg::DATA_W-1:0]     csr_prdata;
   logic                           csr_pready;

   // predictor state
   logic [esa_pkg::LINES_W-1:0] cfg_lines     = esa_pkg::LINES_RESET;
   logic [esa_pkg::LIMIT_W-1:0] cfg_limit     = esa_pkg::LIMIT_RESET;
   logic [esa_pkg::PREV_W-1:0]  last_count    = '0;
   logic                        first_pending = 1'b1;
   logic [esa_pkg::AVG_W-1:0]   speed_window [HISTORY_DEPTH] = '{default: '0};
   logic [esa_pkg::SUM_W-1:0]   window_sum    = '0;
   int                          window_slot   = 0;
   esa_pkg::rsp_type            speed_reports_due [$];

   int mismatches = 0;
   int burst_left = 0;
   int max_gap    = 0;
   int stall_pct  = 0;
   int hold_left  = 0;

   encoder_speed_averager #(.HISTORY_DEPTH(HISTORY_DEPTH)) i_dut (.*);

   always #2 clock = ~clock;

   function automatic int effective_period();
      return EDGES_PER_LINE * ((cfg_lines == 0) ? 1 : int'(cfg_lines));
   endfunction

   function automatic esa_pkg::rsp_type predict_speed_report(input esa_pkg::req_type item);
      esa_pkg::rsp_type res;
      logic [31:0]      period;
      logic [31:0]      span;
      logic [31:0]      diff;
      logic [15:0]      speed;
      longint           q;
      res = '0;
      if (item.func == esa_pkg::FUNC_CLEAR) begin
         foreach (speed_window[i]) speed_window[i] = '0;
         window_sum = '0;
         first_pending = 1'b1;
         return res;
      end
      if (first_pending) begin
         first_pending = 1'b0;
         speed = '0;
      end else begin
         period = 32'(effective_period());
         span = 32'(item.overflow_count) * period;
         diff = 32'(item.count_value) - 32'(last_count);
         diff = item.count_down ? diff - span : diff + span;
         q = (longint'($signed(diff)) * SPEED_FACTOR) / longint'(period);
         speed = q[15:0];
      end
      last_count = esa_pkg::PREV_W'(item.count_value);
      // negative speeds look huge unsigned, so they never pass the limit
      if (32'(speed) < 32'(cfg_limit)) begin
         window_sum = window_sum - esa_pkg::SUM_W'(speed_window[window_slot]) + speed;
         speed_window[window_slot] = speed[esa_pkg::AVG_W-1:0];
         window_slot = (window_slot == HISTORY_DEPTH - 1) ? 0 : window_slot + 1;
         res.stored = 1'b1;
      end
      res.average_speed = esa_pkg::AVG_W'(window_sum / HISTORY_DEPTH);
      res.raw_speed = speed;
      return res;
   endfunction

   // Mostly plausible encoder motion from the last reading, some raw noise, a few clears.
   function automatic esa_pkg::req_type random_item();
      esa_pkg::req_type item;
      int               period;
      int unsigned      reach;
      int               step;
      int               pos;
      int               pick;
      item.func = FUNC_SAMPLE;
      item.count_value = esa_pkg::COUNT_W'($urandom);
      item.overflow_count = esa_pkg::WRAPS_W'($urandom);
      item.count_down = 1'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 4) begin
         item.func = esa_pkg::FUNC_CLEAR;
      end else if (pick >= 24) begin
         period = effective_period();
         if ($urandom_range(99, 0) < 85)
            reach = int'(cfg_limit) * period / int'(SPEED_FACTOR) + 2;
         else
            reach = 3 * period;
         step = int'($urandom_range(reach, 0));
         if ($urandom_range(99, 0) < 20) step = -step;
         pos = int'(last_count) + step;
         if (pos >= 0) begin
            item.overflow_count = esa_pkg::WRAPS_W'(pos / period);
            item.count_value = esa_pkg::COUNT_W'(pos % period);
            if (item.overflow_count != 0) item.count_down = 1'b0;
         end else begin
            item.overflow_count = esa_pkg::WRAPS_W'((period - 1 - pos) / period);
            item.count_value = esa_pkg::COUNT_W'(pos + int'(item.overflow_count) * period);
            item.count_down = 1'b1;
         end
      end
      return item;
   endfunction

   task automatic flag_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   task automatic check_speed_report(input esa_pkg::rsp_type got);
      esa_pkg::rsp_type want;
      if (speed_reports_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 100)
            $display("%0t: unexpected result, expected none, actual avg %0d raw %0d stored %0b",
                     $time, got.average_speed, got.raw_speed, got.stored);
         return;
      end
      want = speed_reports_due.pop_front();
      if (got.average_speed !== want.average_speed)
         flag_field("average_speed", want.average_speed, got.average_speed);
      if (got.raw_speed !== want.raw_speed)
         flag_field("raw_speed", want.raw_speed, got.raw_speed);
      if (got.stored !== want.stored)
         flag_field("stored", want.stored, got.stored);
   endtask

   // result side: check accepted transactions, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_speed_report(rsp_payload);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   task automatic send_item(input esa_pkg::req_type item);
      int gap;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      speed_reports_due.push_back(predict_speed_report(item));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(16, 1);
         gap = (max_gap > 0) ? $urandom_range(max_gap, 0) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_sample(input int count, input int wraps, input logic down);
      esa_pkg::req_type item;
      item.func = FUNC_SAMPLE;
      item.count_value = esa_pkg::COUNT_W'(count);
      item.overflow_count = esa_pkg::WRAPS_W'(wraps);
      item.count_down = down;
      send_item(item);
   endtask

   task automatic send_clear();
      esa_pkg::req_type item;
      item = random_item();
      item.func = esa_pkg::FUNC_CLEAR;
      send_item(item);
   endtask

   // drain all pending results so registers can be touched
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (speed_reports_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic check_register(input logic reg_idx);
      logic [esa_pkg::DATA_W-1:0] want;
      logic [esa_pkg::DATA_W-1:0] mask;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= esa_pkg::CSR_ADDR_W'(reg_idx) << esa_pkg::CSR_IDX_BIT;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (reg_idx == esa_pkg::REG_LINES_PER_REV) begin
         want = esa_pkg::DATA_W'(cfg_lines);
         mask = (1 << esa_pkg::LINES_W) - 1;
      end else begin
         want = esa_pkg::DATA_W'(cfg_limit);
         mask = (1 << esa_pkg::LIMIT_W) - 1;
      end
      if ((csr_prdata & mask) !== want) begin
         mismatches++;
         $display("%0t: register %0d readback, expected %0d, actual %0d",
                  $time, reg_idx, want, csr_prdata & mask);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_register(input logic reg_idx, input int unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= esa_pkg::CSR_ADDR_W'(reg_idx) << esa_pkg::CSR_IDX_BIT;
      csr_pwdata <= esa_pkg::DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_idx == esa_pkg::REG_LINES_PER_REV)
         cfg_lines = esa_pkg::LINES_W'(value);
      else
         cfg_limit = esa_pkg::LIMIT_W'(value);
      @(posedge clock);
      check_register(reg_idx);
   endtask

   task automatic test_reset_values();
      check_register(esa_pkg::REG_LINES_PER_REV);
      check_register(esa_pkg::REG_SPEED_LIMIT);
   endtask

   // reset setup: period 4096, limit 1600
   task automatic test_directed();
      max_gap = 6;
      stall_pct = 25;
      send_sample(100, 0, 1'b0);          // first sample after reset reports zero
      send_sample(1124, 0, 1'b0);
      send_sample(2216, 0, 1'b0);         // 1599, just under the limit
      send_sample(3309, 0, 1'b0);         // 1601, rejected
      send_sample(2809, 0, 1'b1);         // negative speed
      send_sample(3900, 0, 1'b0);
      send_sample(500, 1, 1'b0);          // forward through a wrap
      send_sample(3896, 1, 1'b1);         // reverse through a wrap
      send_sample(3900, 0, 1'b0);
      send_sample(32767, 65535, 1'b0);
      send_sample(0, 65535, 1'b1);
      send_sample(32767, 0, 1'b1);
      send_sample(0, 0, 1'b0);
      send_clear();
      send_sample(5, 0, 1'b0);            // first sample after clear
      send_sample(0, 0, 1'b0);
      for (int i = 1; i <= 9; i++) send_sample(50 * i, 0, 1'b0);  // wraps the window
      settle();
   endtask

   task automatic test_register_extremes();
      program_register(esa_pkg::REG_LINES_PER_REV, 1);
      program_register(esa_pkg::REG_SPEED_LIMIT, 2047);
      repeat (8) send_item(random_item());
      settle();
      program_register(esa_pkg::REG_LINES_PER_REV, 8191);
      program_register(esa_pkg::REG_SPEED_LIMIT, 1);
      repeat (8) send_item(random_item());
      settle();
      // period 4000: a 1000-count step lands exactly on the limit
      program_register(esa_pkg::REG_LINES_PER_REV, 1000);
      program_register(esa_pkg::REG_SPEED_LIMIT, 1500);
      send_clear();
      send_sample(0, 0, 1'b0);
      send_sample(999, 0, 1'b0);
      send_sample(1999, 0, 1'b0);
      send_sample(3000, 0, 1'b0);
      settle();
      // zero lines acts as one line, zero limit stores nothing
      program_register(esa_pkg::REG_LINES_PER_REV, 0);
      program_register(esa_pkg::REG_SPEED_LIMIT, 0);
      repeat (8) send_item(random_item());
      settle();
   endtask

   task automatic test_backpressure();
      program_register(esa_pkg::REG_LINES_PER_REV, 512);
      program_register(esa_pkg::REG_SPEED_LIMIT, 2047);
      max_gap = 0;
      stall_pct = 0;
      hold_left = 300;
      repeat (24) send_item(random_item());
      settle();
   endtask

   task automatic test_random_traffic();
      int unsigned lines;
      int unsigned limit;
      for (int phase = 0; phase < 9; phase++) begin
         unique case (phase)
            0: begin
               lines = esa_pkg::LINES_RESET;
               limit = esa_pkg::LIMIT_RESET;
            end
            1: begin
               lines = 1;
               limit = 2047;
            end
            2: begin
               lines = 8191;
               limit = 2047;
            end
            3: begin
               lines = 8191;
               limit = 1;
            end
            default: begin
               lines = $urandom_range(8191, 1);
               limit = $urandom_range(2047, 1);
            end
         endcase
         if (phase % 3 == 0) begin
            max_gap = 0;
            stall_pct = 0;
         end else begin
            max_gap = $urandom_range(40, 1);
            stall_pct = $urandom_range(60, 5);
         end
         program_register(esa_pkg::REG_LINES_PER_REV, lines);
         program_register(esa_pkg::REG_SPEED_LIMIT, limit);
         repeat (200) send_item(random_item());
         settle();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && speed_reports_due.size() == 0)
         $display("[encoder_speed_averager] OK");
      else
         $display("[encoder_speed_averager] ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[encoder_speed_averager] ERROR");
      $finish;
   end

endmodule
